FILE: hdl/rls_pkg.sv
package rls_pkg;

  localparam int COORD_BITS = 9;
  localparam int ERR_BITS   = COORD_BITS + 1;
  localparam int SUM_BITS   = COORD_BITS + 2;
  localparam int DOTS_BITS  = COORD_BITS + 1;
  localparam int COLOR_BITS = 16;

  localparam int QPTR_BITS   = 2;
  localparam int QUEUE_DEPTH = 1 << QPTR_BITS;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  typedef logic [1:0] dir_t;
  localparam dir_t DIR_NONE  = 2'd0;
  localparam dir_t DIR_PLUS  = 2'd1;
  localparam dir_t DIR_MINUS = 2'd3;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  typedef struct packed {
    logic   mode;
    coord_t start_col;
    coord_t start_row;
    coord_t end_col;
    coord_t end_row;
    color_t pen_color;
  } item_t;

  typedef struct packed {
    coord_t dot_col;
    coord_t dot_row;
    color_t dot_color;
    logic   last_dot;
  } result_t;

  // Classified command as it travels from the front end to the stepper.
  typedef struct packed {
    logic   is_load;
    coord_t start_col;
    coord_t start_row;
    coord_t abs_dcol;
    coord_t abs_drow;
    dir_t   dir_col;
    dir_t   dir_row;
    coord_t major_distance;
    color_t color;
  } cmd_t;

  typedef struct packed {
    logic                 full;
    logic                 empty;
    logic [QPTR_BITS:0]   count;
  } queue_status_t;

  typedef struct packed {
    logic [1:0] count;
  } out_status_t;

endpackage

FILE: hdl/rls_front.sv
module rls_front (
  input  logic                  push,
  input  rls_pkg::item_t        item,
  input  rls_pkg::queue_status_t qstat,
  output logic                  wr_en,
  output rls_pkg::cmd_t         cmd
);

  rls_pkg::coord_t adc;
  rls_pkg::coord_t adr;
  rls_pkg::dir_t   dc;
  rls_pkg::dir_t   dr;

  always_comb begin
    if (item.end_col > item.start_col) begin
      dc  = rls_pkg::DIR_PLUS;
      adc = item.end_col - item.start_col;
    end else if (item.end_col < item.start_col) begin
      dc  = rls_pkg::DIR_MINUS;
      adc = item.start_col - item.end_col;
    end else begin
      dc  = rls_pkg::DIR_NONE;
      adc = '0;
    end

    if (item.end_row > item.start_row) begin
      dr  = rls_pkg::DIR_PLUS;
      adr = item.end_row - item.start_row;
    end else if (item.end_row < item.start_row) begin
      dr  = rls_pkg::DIR_MINUS;
      adr = item.start_row - item.end_row;
    end else begin
      dr  = rls_pkg::DIR_NONE;
      adr = '0;
    end

    cmd.is_load        = (item.mode == rls_pkg::MODE_LOAD);
    cmd.start_col      = item.start_col;
    cmd.start_row      = item.start_row;
    cmd.abs_dcol       = adc;
    cmd.abs_drow       = adr;
    cmd.dir_col        = dc;
    cmd.dir_row        = dr;
    cmd.major_distance = (adc > adr) ? adc : adr;
    cmd.color          = item.pen_color;
  end

  assign wr_en = push && !qstat.full;

endmodule

FILE: hdl/rls_cmd_queue.sv
module rls_cmd_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  rls_pkg::cmd_t          wr_data,
  input  logic                   rd_en,
  output rls_pkg::cmd_t          rd_data,
  output rls_pkg::queue_status_t qstat
);

  localparam logic [rls_pkg::QPTR_BITS:0] DEPTH_CNT =
    (rls_pkg::QPTR_BITS + 1)'(rls_pkg::QUEUE_DEPTH);

  rls_pkg::cmd_t                  mem [rls_pkg::QUEUE_DEPTH];
  logic [rls_pkg::QPTR_BITS-1:0]  wr_ptr;
  logic [rls_pkg::QPTR_BITS-1:0]  rd_ptr;
  logic [rls_pkg::QPTR_BITS:0]    count;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  assign rd_data     = mem[rd_ptr];
  assign qstat.full  = (count == DEPTH_CNT);
  assign qstat.empty = (count == '0);
  assign qstat.count = count;

endmodule

FILE: hdl/rls_back.sv
module rls_back (
  input  logic                   clk,
  input  logic                   rst,
  input  rls_pkg::cmd_t          q_cmd,
  input  rls_pkg::queue_status_t qstat,
  output logic                   q_pop,
  input  logic                   pop,
  output logic                   empty,
  output rls_pkg::result_t       result,
  output rls_pkg::out_status_t   ostat
);

  localparam int SB = rls_pkg::SUM_BITS;

  rls_pkg::coord_t cur_col;
  rls_pkg::coord_t cur_row;
  logic [rls_pkg::ERR_BITS-1:0]  err_col;
  logic [rls_pkg::ERR_BITS-1:0]  err_row;
  rls_pkg::coord_t abs_dcol;
  rls_pkg::coord_t abs_drow;
  rls_pkg::dir_t   dir_col;
  rls_pkg::dir_t   dir_row;
  rls_pkg::coord_t major_distance;
  logic [rls_pkg::DOTS_BITS-1:0] dots_left;
  rls_pkg::color_t line_color;

  rls_pkg::result_t obuf [2];
  logic       owr;
  logic       ord;
  logic [1:0] ocount;

  logic            out_room;
  logic            emit;
  logic            pop_ok;
  logic [SB-1:0]   sum_col;
  logic [SB-1:0]   sum_row;
  logic [SB-1:0]   dist_ext;
  logic [rls_pkg::ERR_BITS-1:0] err_col_next;
  logic [rls_pkg::ERR_BITS-1:0] err_row_next;
  rls_pkg::coord_t cur_col_next;
  rls_pkg::coord_t cur_row_next;
  rls_pkg::result_t dot;

  function automatic rls_pkg::coord_t move_by(rls_pkg::coord_t pos, rls_pkg::dir_t dir);
    rls_pkg::coord_t r;
    case (dir)
      rls_pkg::DIR_PLUS:  r = pos + 1'b1;
      rls_pkg::DIR_MINUS: r = pos - 1'b1;
      default:            r = pos;
    endcase
    return r;
  endfunction

  assign out_room = (ocount != 2'd2);
  assign q_pop    = !qstat.empty && (q_cmd.is_load || out_room);
  assign emit     = q_pop && !q_cmd.is_load && (dots_left != '0);
  assign pop_ok   = pop && (ocount != 2'd0);

  // Error sums stay at or below the distance, so one subtract folds them back.
  always_comb begin
    dist_ext = {2'b00, major_distance};
    sum_col  = {1'b0, err_col} + {2'b00, abs_dcol};
    sum_row  = {1'b0, err_row} + {2'b00, abs_drow};
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    if (sum_col > dist_ext) begin
      sum_col      = sum_col - dist_ext;
      cur_col_next = move_by(cur_col, dir_col);
    end
    if (sum_row > dist_ext) begin
      sum_row      = sum_row - dist_ext;
      cur_row_next = move_by(cur_row, dir_row);
    end
    err_col_next = sum_col[rls_pkg::ERR_BITS-1:0];
    err_row_next = sum_row[rls_pkg::ERR_BITS-1:0];

    dot.dot_col   = cur_col;
    dot.dot_row   = cur_row;
    dot.dot_color = line_color;
    dot.last_dot  = (dots_left == rls_pkg::DOTS_BITS'(1));
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.is_load) begin
      cur_col        <= q_cmd.start_col;
      cur_row        <= q_cmd.start_row;
      err_col        <= '0;
      err_row        <= '0;
      abs_dcol       <= q_cmd.abs_dcol;
      abs_drow       <= q_cmd.abs_drow;
      dir_col        <= q_cmd.dir_col;
      dir_row        <= q_cmd.dir_row;
      major_distance <= q_cmd.major_distance;
      line_color     <= q_cmd.color;
    end else if (emit) begin
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
      err_col <= err_col_next;
      err_row <= err_row_next;
    end
    if (emit) begin
      obuf[owr] <= dot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dots_left <= '0;
      owr       <= 1'b0;
      ord       <= 1'b0;
      ocount    <= 2'd0;
    end else begin
      if (q_pop && q_cmd.is_load) begin
        dots_left <= {1'b0, q_cmd.major_distance} + rls_pkg::DOTS_BITS'(2);
      end else if (emit) begin
        dots_left <= dots_left - 1'b1;
      end
      if (emit) begin
        owr <= ~owr;
      end
      if (pop_ok) begin
        ord <= ~ord;
      end
      if (emit && !pop_ok) begin
        ocount <= ocount + 2'd1;
      end else if (pop_ok && !emit) begin
        ocount <= ocount - 2'd1;
      end
    end
  end

  assign empty       = (ocount == 2'd0);
  assign result      = obuf[ord];
  assign ostat.count = ocount;

endmodule

FILE: hdl/raster_line_stepper.sv
// Line rasterizer: push a load word (mode 0) with two endpoints and a color, then push one
// step word (mode 1) per dot wanted. Each step while a line is armed yields one dot; a line
// of major distance D gives D+2 dots, the start dot appearing twice, and the final dot has
// last_dot set. Steps with no line armed give nothing, and a load replaces any line at once.
// The block takes one word per clock and returns one dot per clock when the consumer pops
// every cycle; a step word is registered in the command queue and its dot is then registered
// in the result buffer, from which it is popped.
// That rate is set by the stepping unit, which updates both error sums and the position
// together, behind a four-entry command queue and a two-entry result buffer.
module raster_line_stepper (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  rls_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output rls_pkg::result_t result
);

  logic                   wr_en;
  rls_pkg::cmd_t          wr_cmd;
  rls_pkg::cmd_t          q_cmd;
  logic                   q_pop;
  rls_pkg::queue_status_t qstat;
  rls_pkg::out_status_t   ostat;

  rls_front u_front (
    .push  (push),
    .item  (item),
    .qstat (qstat),
    .wr_en (wr_en),
    .cmd   (wr_cmd)
  );

  rls_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_cmd),
    .rd_en   (q_pop),
    .rd_data (q_cmd),
    .qstat   (qstat)
  );

  rls_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_cmd  (q_cmd),
    .qstat  (qstat),
    .q_pop  (q_pop),
    .pop    (pop),
    .empty  (empty),
    .result (result),
    .ostat  (ostat)
  );

  assign full = qstat.full;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= (rls_pkg::QPTR_BITS + 1)'(rls_pkg::QUEUE_DEPTH))
    else $error("command queue count out of range");

  a_out_bound: assert property (@(posedge clk) disable iff (rst)
    ostat.count != 2'd3)
    else $error("result buffer count out of range");

  a_no_empty_read: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !qstat.empty)
    else $error("stepper read an empty command queue");

  a_queue_idle: assert property (@(posedge clk) disable iff (rst)
    (qstat.empty && !(push && !full)) |=> qstat.empty)
    else $error("command appeared without a push");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> empty)
    else $error("result side not empty after reset");

endmodule

FILE: dv/tb_raster_line_stepper.sv
`timescale 1ns / 1ps

module tb_raster_line_stepper;

  localparam int LIMIT_CYCLES = 500000;
  localparam int COORD_MAX    = (1 << rls_pkg::COORD_BITS) - 1;

  // Predicts the dots of the line stepper and checks each popped dot in order.
  class dot_scoreboard;
    rls_pkg::coord_t                pos_col, pos_row;
    logic [rls_pkg::ERR_BITS-1:0]   sum_col, sum_row;
    rls_pkg::coord_t                dcol, drow, major_dist;
    rls_pkg::dir_t                  dir_c, dir_r;
    logic [rls_pkg::DOTS_BITS-1:0]  remaining;
    rls_pkg::color_t                color;
    rls_pkg::result_t               expected_dots[$];
    int                             fails;

    function new();
      pos_col = '0;
      pos_row = '0;
      sum_col = '0;
      sum_row = '0;
      dcol = '0;
      drow = '0;
      major_dist = '0;
      dir_c = rls_pkg::DIR_NONE;
      dir_r = rls_pkg::DIR_NONE;
      remaining = '0;
      color = '0;
      fails = 0;
    endfunction

    function void axis_delta(input rls_pkg::coord_t a, input rls_pkg::coord_t b,
                             output rls_pkg::coord_t d, output rls_pkg::dir_t dir);
      if (b > a) begin
        dir = rls_pkg::DIR_PLUS;
        d = b - a;
      end else if (b < a) begin
        dir = rls_pkg::DIR_MINUS;
        d = a - b;
      end else begin
        dir = rls_pkg::DIR_NONE;
        d = '0;
      end
    endfunction

    // Adds the delta to the error sum; once it passes the distance, fold it back
    // and move the coordinate one pixel. The position wraps at the coordinate width.
    function void step_axis(inout logic [rls_pkg::ERR_BITS-1:0] sum,
                            input rls_pkg::coord_t d, inout rls_pkg::coord_t pos,
                            input rls_pkg::dir_t dir);
      logic [rls_pkg::SUM_BITS-1:0] total;
      total = rls_pkg::SUM_BITS'(sum) + rls_pkg::SUM_BITS'(d);
      if (total > rls_pkg::SUM_BITS'(major_dist)) begin
        total = total - rls_pkg::SUM_BITS'(major_dist);
        if (dir == rls_pkg::DIR_PLUS) pos = pos + 1'b1;
        else if (dir == rls_pkg::DIR_MINUS) pos = pos - 1'b1;
      end
      sum = total[rls_pkg::ERR_BITS-1:0];
    endfunction

    function void note_word(rls_pkg::item_t w);
      rls_pkg::result_t dot;
      if (w.mode == rls_pkg::MODE_LOAD) begin
        axis_delta(w.start_col, w.end_col, dcol, dir_c);
        axis_delta(w.start_row, w.end_row, drow, dir_r);
        major_dist = (dcol > drow) ? dcol : drow;
        sum_col = '0;
        sum_row = '0;
        pos_col = w.start_col;
        pos_row = w.start_row;
        color = w.pen_color;
        remaining = rls_pkg::DOTS_BITS'(major_dist) + rls_pkg::DOTS_BITS'(2);
      end else if (remaining != '0) begin
        dot.dot_col = pos_col;
        dot.dot_row = pos_row;
        dot.dot_color = color;
        dot.last_dot = (remaining == rls_pkg::DOTS_BITS'(1));
        expected_dots.push_back(dot);
        step_axis(sum_col, dcol, pos_col, dir_c);
        step_axis(sum_row, drow, pos_row, dir_r);
        remaining = remaining - 1'b1;
      end
    endfunction

    function void check_dot(rls_pkg::result_t got);
      rls_pkg::result_t want;
      if (expected_dots.size() == 0) begin
        $error("dot with none expected: col %0d row %0d color %0h last %0b",
               got.dot_col, got.dot_row, got.dot_color, got.last_dot);
        fails++;
        return;
      end
      want = expected_dots.pop_front();
      if (got.dot_col !== want.dot_col) begin
        $error("dot_col: expected %0d, actual %0d", want.dot_col, got.dot_col);
        fails++;
      end
      if (got.dot_row !== want.dot_row) begin
        $error("dot_row: expected %0d, actual %0d", want.dot_row, got.dot_row);
        fails++;
      end
      if (got.dot_color !== want.dot_color) begin
        $error("dot_color: expected %0h, actual %0h", want.dot_color, got.dot_color);
        fails++;
      end
      if (got.last_dot !== want.last_dot) begin
        $error("last_dot: expected %0b, actual %0b", want.last_dot, got.last_dot);
        fails++;
      end
    endfunction

    function int pending();
      return expected_dots.size();
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             push;
  logic             full;
  rls_pkg::item_t   item;
  logic             empty;
  logic             pop;
  rls_pkg::result_t result;

  dot_scoreboard sb = new();
  bit            quiet;
  int            cycles;

  raster_line_stepper u_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sb.note_word(item);
      if (pop && !empty) sb.check_dot(result);
    end
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("** raster_line_stepper: FAILED **");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, none at all during a quiet stretch.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_near(int c, int span);
    int lo, hi;
    lo = (c > span) ? c - span : 0;
    hi = (c + span > COORD_MAX) ? COORD_MAX : c + span;
    return $urandom_range(lo, hi);
  endfunction

  function automatic rls_pkg::item_t make_word(logic mode, rls_pkg::coord_t sc,
                                               rls_pkg::coord_t sr, rls_pkg::coord_t ec,
                                               rls_pkg::coord_t er, rls_pkg::color_t c);
    rls_pkg::item_t w;
    w.mode = mode;
    w.start_col = sc;
    w.start_row = sr;
    w.end_col = ec;
    w.end_row = er;
    w.pen_color = c;
    return w;
  endfunction

  // Returns at the edge where the word is taken; push stays high until the
  // next call or an explicit drop.
  task automatic send_word(input rls_pkg::item_t w);
    int n;
    n = pick_gap();
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
    push <= 1'b1;
    item <= w;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic load_line(input int sc, input int sr, input int ec, input int er,
                           input int c);
    send_word(make_word(rls_pkg::MODE_LOAD, rls_pkg::coord_t'(sc), rls_pkg::coord_t'(sr),
                        rls_pkg::coord_t'(ec), rls_pkg::coord_t'(er),
                        rls_pkg::color_t'(c)));
  endtask

  // Step words carry random junk in the fields the block ignores.
  task automatic step_dots(input int n);
    repeat (n) begin
      send_word(make_word(rls_pkg::MODE_STEP, rls_pkg::coord_t'($urandom),
                          rls_pkg::coord_t'($urandom), rls_pkg::coord_t'($urandom),
                          rls_pkg::coord_t'($urandom), rls_pkg::color_t'($urandom)));
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int n;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        pop <= 1'b0;
        repeat (n) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    int sent, kind, span, shape, n, line_len;
    int sc, sr, ec, er;
    bit held;

    rst <= 1'b1;
    push <= 1'b0;
    item <= '0;
    quiet = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A step with no line armed does nothing.
    step_dots(1);
    // Zero-length line: two dots at the start point, then idle again.
    load_line(0, 0, 0, 0, 16'h0000);
    step_dots(3);
    // Longest line in both axes, cut short by a new load.
    load_line(COORD_MAX, COORD_MAX, 0, 0, 16'hFFFF);
    step_dots(2);
    // The update after the final dot wraps past the top of the range.
    load_line(COORD_MAX - 1, 5, COORD_MAX, 5, 16'hA5A5);
    step_dots(4);
    // Same at the bottom, moving down from column 1.
    load_line(1, 3, 0, 3, 16'h5A5A);
    step_dots(3);
    // Steep line, row is the major axis.
    load_line(10, 20, 11, 23, 16'h07E0);
    step_dots(5);

    sent = 0;
    held = 1'b0;
    while (sent < 600) begin
      if ($urandom_range(0, 9) == 0) quiet = !quiet;
      if ((sent >= 300 && !held) || $urandom_range(0, 49) == 0) begin
        wait_drained();
        held = 1'b1;
      end
      kind = $urandom_range(0, 99);
      span = (kind < 80) ? 6 : (kind < 95) ? 40 : COORD_MAX;
      sc = $urandom_range(0, COORD_MAX);
      sr = $urandom_range(0, COORD_MAX);
      if ($urandom_range(0, 19) == 0) sc = $urandom_range(0, 1) ? COORD_MAX : 0;
      if ($urandom_range(0, 19) == 0) sr = $urandom_range(0, 1) ? COORD_MAX : 0;
      ec = pick_near(sc, span);
      er = pick_near(sr, span);
      line_len = (ec > sc) ? ec - sc : sc - ec;
      if (((er > sr) ? er - sr : sr - er) > line_len) begin
        line_len = (er > sr) ? er - sr : sr - er;
      end

      load_line(sc, sr, ec, er, $urandom);
      sent++;
      shape = $urandom_range(0, 99);
      if (line_len > 40) n = $urandom_range(0, 24);
      else if (shape < 75) n = line_len + 2;
      else if (shape < 90) n = $urandom_range(0, line_len + 1);
      else n = line_len + 2 + $urandom_range(1, 3);
      step_dots(n);
      sent += (n < line_len + 2) ? n : line_len + 2;
    end

    wait_drained();
    repeat (24) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("** raster_line_stepper: PASSED **");
    end else begin
      $display("** raster_line_stepper: FAILED **");
    end
    $finish;
  end

endmodule
